@@ src/tkts_pkg.sv @@
`timescale 1ns / 1ps
package tkts_pkg;

    localparam int ENTRIES = 256;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CNT_W   = ADDR_W + 1;

    localparam logic [2:0] FUNC_APPEND    = 3'd0;
    localparam logic [2:0] FUNC_SORT      = 3'd1;
    localparam logic [2:0] FUNC_FIND_KEY  = 3'd2;
    localparam logic [2:0] FUNC_FIND_IDX  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;

    localparam logic [2:0] TYPE_BOOL = 3'd0;
    localparam logic [2:0] TYPE_LAST = 3'd4;
    localparam logic [2:0] TYPE_NONE = 3'd5;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [23:0] key;
        logic [2:0]  want_type;
        logic [31:0] data_word;
        logic [7:0]  position;
    } t_req;

    typedef struct packed {
        logic [23:0] key;
        logic [2:0]  etype;
        logic [31:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        valid;
        logic        found;
        logic [2:0]  stored_type;
        logic [31:0] result_word;
        logic        status;
    } t_result;

endpackage

@@ src/tkts_ram.sv @@
`timescale 1ns / 1ps
module tkts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tkts_ctrl.sv @@
`timescale 1ns / 1ps
module tkts_ctrl
    import tkts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_req    i_req,
    output logic    o_req_ready,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SORT_GAP  = 4'd1;
    localparam logic [3:0] S_SORT_RDA  = 4'd2;
    localparam logic [3:0] S_SORT_RDB  = 4'd3;
    localparam logic [3:0] S_SORT_CMP  = 4'd4;
    localparam logic [3:0] S_SORT_SWP  = 4'd5;
    localparam logic [3:0] S_BS_ADDR   = 4'd6;
    localparam logic [3:0] S_BS_CMP    = 4'd7;
    localparam logic [3:0] S_IDX_RD    = 4'd8;
    localparam logic [3:0] S_RESP      = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_gap, n_gap;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [23:0]      r_key, n_key;
    logic [2:0]       r_want, n_want;
    t_entry           r_ea, n_ea;
    logic             r_found, n_found;
    logic [2:0]       r_stype, n_stype;
    logic [31:0]      r_word, n_word;
    logic             r_status, n_status;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_entry             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    logic [23:0]      cmp_a;
    logic             cmp_gt;
    logic             cmp_lt;
    logic [CNT_W:0]   bs_sum;
    logic [CNT_W-1:0] bs_mid;
    logic [CNT_W-1:0] jg_sum;
    logic [CNT_W-1:0] half_gap;
    logic             rep_match;
    logic [31:0]      rep_word;

    tkts_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    // shared key comparator for sort and search
    assign cmp_a  = (r_state == S_SORT_CMP) ? r_ea.key : r_key;
    assign cmp_gt = cmp_a > rd_entry.key;
    assign cmp_lt = cmp_a < rd_entry.key;

    assign bs_sum   = {1'b0, r_hi} + {1'b0, r_lo} - (CNT_W + 1)'(1);
    assign bs_mid   = bs_sum[CNT_W:1];
    assign jg_sum   = r_j + r_gap;
    assign half_gap = r_gap >> 1;

    assign rep_match = (rd_entry.etype == r_want);
    assign rep_word  = (rd_entry.etype == TYPE_BOOL) ?
                       {31'd0, ((rd_entry.value[7:0] & BYTE_MASK) != 8'd0)} :
                       rd_entry.value;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_res.valid       = (r_state == S_RESP);
        o_res.found       = r_found;
        o_res.stored_type = r_stype;
        o_res.result_word = r_word;
        o_res.status      = r_status;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_gap     = r_gap;
        n_i       = r_i;
        n_j       = r_j;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_key     = r_key;
        n_want    = r_want;
        n_ea      = r_ea;
        n_found   = r_found;
        n_stype   = r_stype;
        n_word    = r_word;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[ADDR_W-1:0];
        ram_wdata = rd_entry;
        ram_raddr = r_j[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_key    = i_req.key;
                    n_want   = i_req.want_type;
                    n_found  = 1'b0;
                    n_stype  = TYPE_NONE;
                    n_word   = 32'd0;
                    n_status = 1'b0;
                    n_state  = S_RESP;
                    case (i_req.func)
                        FUNC_APPEND: begin
                            if (r_cnt >= CNT_W'(ENTRIES)) begin
                                n_status = 1'b1;
                            end else if (i_req.want_type <= TYPE_LAST) begin
                                ram_we          = 1'b1;
                                ram_waddr       = r_cnt[ADDR_W-1:0];
                                ram_wdata.key   = i_req.key;
                                ram_wdata.etype = i_req.want_type;
                                ram_wdata.value = i_req.data_word;
                                n_cnt           = r_cnt + CNT_W'(1);
                            end
                        end
                        FUNC_SORT: begin
                            n_gap = r_cnt >> 1;
                            n_i   = r_cnt >> 1;
                            if ((r_cnt >> 1) != CNT_W'(0)) begin
                                n_state = S_SORT_GAP;
                            end
                        end
                        FUNC_FIND_KEY: begin
                            n_lo = CNT_W'(0);
                            n_hi = r_cnt;
                            if (r_cnt != CNT_W'(0)) begin
                                n_state = S_BS_ADDR;
                            end
                        end
                        FUNC_FIND_IDX: begin
                            ram_raddr = i_req.position[ADDR_W-1:0];
                            if ({1'b0, i_req.position} < r_cnt) begin
                                n_state = S_IDX_RD;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_cnt = CNT_W'(0);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SORT_GAP: begin
                if (r_i >= r_cnt) begin
                    n_gap = half_gap;
                    n_i   = half_gap;
                    if (half_gap == CNT_W'(0)) begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_j     = r_i - r_gap;
                    n_state = S_SORT_RDA;
                end
            end
            S_SORT_RDA: begin
                ram_raddr = r_j[ADDR_W-1:0];
                n_state   = S_SORT_RDB;
            end
            S_SORT_RDB: begin
                ram_raddr = jg_sum[ADDR_W-1:0];
                n_ea      = rd_entry;
                n_state   = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (cmp_gt) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[ADDR_W-1:0];
                    ram_wdata = rd_entry;
                    n_state   = S_SORT_SWP;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SORT_GAP;
                end
            end
            S_SORT_SWP: begin
                ram_we    = 1'b1;
                ram_waddr = jg_sum[ADDR_W-1:0];
                ram_wdata = r_ea;
                if (r_j < r_gap) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SORT_GAP;
                end else begin
                    n_j     = r_j - r_gap;
                    n_state = S_SORT_RDA;
                end
            end
            S_BS_ADDR: begin
                ram_raddr = bs_mid[ADDR_W-1:0];
                n_mid     = bs_mid;
                n_state   = S_BS_CMP;
            end
            S_BS_CMP: begin
                if (cmp_gt) begin
                    n_lo = r_mid + CNT_W'(1);
                end else if (cmp_lt) begin
                    n_hi = r_mid;
                end
                if (!cmp_gt && !cmp_lt) begin
                    n_stype = rd_entry.etype;
                    n_found = rep_match;
                    n_word  = rep_match ? rep_word : 32'd0;
                    n_state = S_RESP;
                end else if (n_lo < n_hi) begin
                    n_state = S_BS_ADDR;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_IDX_RD: begin
                n_stype = rd_entry.etype;
                n_found = rep_match;
                n_word  = rep_match ? rep_word : 32'd0;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= CNT_W'(0);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap    <= n_gap;
        r_i      <= n_i;
        r_j      <= n_j;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_want   <= n_want;
        r_ea     <= n_ea;
        r_found  <= n_found;
        r_stype  <= n_stype;
        r_word   <= n_word;
        r_status <= n_status;
    end

endmodule

@@ src/typed_key_table_sort_search.sv @@
`timescale 1ns / 1ps
// Typed key table: append, shell sort by key, binary search by key, lookup by
// index and clear, one result beat per request beat. Requests are handled one
// at a time by a sequencer around a table memory with one write port, one
// registered read port and one shared key comparator. Lookup by key takes at
// most 9 binary search steps; sort reads, compares and swaps entries through
// the one read port. A finished result waits in an output register so the next
// request can be taken while it is pending. The table holds no clearing pass.
module typed_key_table_sort_search
    import tkts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // key[23:0], data_word[55:24], position[63:56]
    input  logic [63:0] i_s_axis_tdata,
    // func[2:0], want_type[5:3], zero[7:6]
    input  logic [7:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_word[31:0]
    output logic [31:0] o_m_axis_tdata,
    // found[0], stored_type[3:1], status[4], zero[7:5]
    output logic [7:0]  o_m_axis_tuser
);

    t_req    req;
    t_result res;
    logic    res_ready;

    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_found;
    logic [2:0]  r_out_stype;
    logic        r_out_status;

    assign req.func      = i_s_axis_tuser[2:0];
    assign req.want_type = i_s_axis_tuser[5:3];
    assign req.key       = i_s_axis_tdata[23:0];
    assign req.data_word = i_s_axis_tdata[55:24];
    assign req.position  = i_s_axis_tdata[63:56];

    assign res_ready = !r_out_valid || i_m_axis_tready;

    tkts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (o_s_axis_tready),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_word   <= res.result_word;
            r_out_found  <= res.found;
            r_out_stype  <= res.stored_type;
            r_out_status <= res.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;
    assign o_m_axis_tuser  = {3'd0, r_out_status, r_out_stype, r_out_found};

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import tkts_pkg::*;

    localparam logic [2:0] TYPE_INT   = 3'd1;
    localparam logic [2:0] TYPE_REAL  = 3'd2;
    localparam logic [2:0] TYPE_ASCII = 3'd3;
    localparam logic [2:0] TYPE_BAD   = 3'd7;
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_BEATS  = 120;
    localparam int SETTLE_CYCLES = 40;

    class key_table_tracker;
        logic [23:0] key_mem [ENTRIES];
        logic [2:0]  type_mem [ENTRIES];
        logic [31:0] value_mem [ENTRIES];
        int          fill;
        t_result     replies_due[$];
        int          mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function t_result describe_slot(int slot, logic [2:0] want);
            t_result res;
            res.valid = 1'b1;
            res.found = 1'b0;
            res.stored_type = type_mem[slot];
            res.result_word = '0;
            res.status = 1'b0;
            if (type_mem[slot] == want) begin
                res.found = 1'b1;
                if (type_mem[slot] == TYPE_BOOL)
                    res.result_word = {31'd0, (value_mem[slot][7:0] & BYTE_MASK) != 8'd0};
                else
                    res.result_word = value_mem[slot];
            end
            return res;
        endfunction

        function void note_request(t_req r);
            t_result     res;
            int          gap, i, j, lo, hi, mid;
            bit          go, hit;
            logic [23:0] tk;
            logic [2:0]  tt;
            logic [31:0] tv;
            res.valid = 1'b1;
            res.found = 1'b0;
            res.stored_type = TYPE_NONE;
            res.result_word = '0;
            res.status = 1'b0;
            case (r.func)
                FUNC_APPEND: begin
                    if (fill >= ENTRIES) begin
                        res.status = 1'b1;
                    end else if (r.want_type <= TYPE_LAST) begin
                        key_mem[fill] = r.key;
                        type_mem[fill] = r.want_type;
                        value_mem[fill] = r.data_word;
                        fill++;
                    end
                end
                FUNC_SORT: begin
                    for (gap = fill >> 1; gap > 0; gap = gap >> 1) begin
                        for (i = gap; i < fill; i++) begin
                            j = i - gap;
                            go = 1'b1;
                            while (go) begin
                                if (key_mem[j] > key_mem[j + gap]) begin
                                    tk = key_mem[j];
                                    tt = type_mem[j];
                                    tv = value_mem[j];
                                    key_mem[j] = key_mem[j + gap];
                                    type_mem[j] = type_mem[j + gap];
                                    value_mem[j] = value_mem[j + gap];
                                    key_mem[j + gap] = tk;
                                    type_mem[j + gap] = tt;
                                    value_mem[j + gap] = tv;
                                    if (j < gap)
                                        go = 1'b0;
                                    else
                                        j = j - gap;
                                end else begin
                                    go = 1'b0;
                                end
                            end
                        end
                    end
                end
                FUNC_FIND_KEY: begin
                    lo = 0;
                    hi = fill;
                    mid = 0;
                    hit = 1'b0;
                    if (hi != 0) begin
                        do begin
                            mid = (hi + lo - 1) >> 1;
                            if (r.key > key_mem[mid])
                                lo = mid + 1;
                            else if (r.key < key_mem[mid])
                                hi = mid;
                            else
                                hit = 1'b1;
                        end while (lo < hi && !hit);
                    end
                    if (hit)
                        res = describe_slot(mid, r.want_type);
                end
                FUNC_FIND_IDX: begin
                    if (int'(r.position) < fill)
                        res = describe_slot(int'(r.position), r.want_type);
                end
                FUNC_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            replies_due.push_back(res);
        endfunction

        function void check_reply(logic found, logic [2:0] stored_type,
                                  logic [31:0] result_word, logic status);
            t_result due;
            if (replies_due.size() == 0) begin
                $error("result beat with no request pending");
                mismatches++;
                return;
            end
            due = replies_due.pop_front();
            if (found !== due.found) begin
                $error("found: expected %0d, got %0d", due.found, found);
                mismatches++;
            end
            if (stored_type !== due.stored_type) begin
                $error("stored_type: expected %0d, got %0d", due.stored_type, stored_type);
                mismatches++;
            end
            if (result_word !== due.result_word) begin
                $error("result_word: expected %h, got %h", due.result_word, result_word);
                mismatches++;
            end
            if (status !== due.status) begin
                $error("status: expected %0d, got %0d", due.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // key[23:0], data_word[55:24], position[63:56]
    logic [63:0] i_s_axis_tdata = '0;
    // func[2:0], want_type[5:3], zero[7:6]
    logic [7:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    // result_word[31:0]
    logic [31:0] o_m_axis_tdata;
    // found[0], stored_type[3:1], status[4], zero[7:5]
    logic [7:0]  o_m_axis_tuser;

    key_table_tracker tracker = new();
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int beats_sent = 0;
    int cycle_count = 0;

    typed_key_table_sort_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_reply(o_m_axis_tuser[0], o_m_axis_tuser[3:1],
                                o_m_axis_tdata, o_m_axis_tuser[4]);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with tvalid still up
    task automatic send_req(input logic [2:0] func, input logic [23:0] key,
                            input logic [2:0] want_type, input logic [31:0] data_word,
                            input logic [7:0] position);
        t_req req;
        req.func = func;
        req.key = key;
        req.want_type = want_type;
        req.data_word = data_word;
        req.position = position;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata = {req.position, req.data_word, req.key};
        i_s_axis_tuser = {2'b00, req.want_type, req.func};
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        tracker.note_request(req);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid = 1'b0;
        while (tracker.replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [23:0] random_key(int mode);
        case (mode)
            0: return 24'($urandom_range(15));
            1: return 24'($urandom());
            default: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        endcase
    endfunction

    task automatic run_directed();
        int f;
        send_req(FUNC_FIND_KEY, 24'h000000, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_IDX, 24'h000000, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_SORT, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_APPEND, 24'hFFFFFF, TYPE_LAST, 32'hFFFFFFFF, 8'hFF);
        send_req(FUNC_APPEND, 24'h000000, TYPE_BOOL, 32'h00000100, 8'd0);
        send_req(FUNC_APPEND, 24'h800000, TYPE_BOOL, 32'h00000001, 8'd0);
        send_req(FUNC_APPEND, 24'h123456, TYPE_INT, 32'h80000000, 8'd0);
        send_req(FUNC_APPEND, 24'h00FF00, TYPE_REAL, 32'h3F800000, 8'd0);
        send_req(FUNC_APPEND, 24'h7FFFFF, TYPE_ASCII, 32'h00000000, 8'd0);
        // bad type codes, nothing stored
        send_req(FUNC_APPEND, 24'h555555, TYPE_BAD, 32'hA5A5A5A5, 8'd0);
        send_req(FUNC_APPEND, 24'h2AAAAA, TYPE_NONE, 32'h5A5A5A5A, 8'd0);
        send_req(FUNC_FIND_KEY, 24'h123456, TYPE_INT, 32'h0, 8'd0);
        send_req(FUNC_SORT, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_KEY, 24'h000000, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_KEY, 24'h800000, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_KEY, 24'hFFFFFF, TYPE_LAST, 32'h0, 8'd0);
        send_req(FUNC_FIND_KEY, 24'h123456, TYPE_REAL, 32'h0, 8'd0);
        send_req(FUNC_FIND_KEY, 24'h555555, TYPE_INT, 32'h0, 8'd0);
        send_req(FUNC_FIND_IDX, 24'h0, TYPE_ASCII, 32'h0, 8'd5);
        send_req(FUNC_FIND_IDX, 24'h0, TYPE_LAST, 32'h0, 8'd6);
        send_req(FUNC_FIND_IDX, 24'hFFFFFF, TYPE_BOOL, 32'hFFFFFFFF, 8'hFF);
        for (f = int'(FUNC_SPARE_LO); f <= int'(FUNC_SPARE_HI); f++)
            send_req(3'(f), 24'($urandom()), 3'($urandom()), $urandom(), 8'($urandom()));
        send_req(FUNC_CLEAR, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_IDX, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_KEY, 24'hFFFFFF, TYPE_LAST, 32'h0, 8'd0);
    endtask

    task automatic run_full_table();
        int i, idx;
        send_req(FUNC_CLEAR, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        for (i = 0; i < ENTRIES; i++)
            send_req(FUNC_APPEND, random_key($urandom_range(1, 2)),
                     3'($urandom_range(TYPE_LAST)), $urandom(), 8'($urandom()));
        // table full: both refused
        send_req(FUNC_APPEND, 24'($urandom()), TYPE_INT, $urandom(), 8'd0);
        send_req(FUNC_APPEND, 24'($urandom()), TYPE_BAD, $urandom(), 8'd0);
        send_req(FUNC_FIND_IDX, 24'h0, 3'($urandom_range(TYPE_LAST)), 32'h0, 8'hFF);
        send_req(FUNC_FIND_IDX, 24'h0, 3'($urandom_range(TYPE_LAST)), 32'h0, 8'h00);
        send_req(FUNC_SORT, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        for (i = 0; i < 8; i++) begin
            idx = $urandom_range(ENTRIES - 1);
            send_req(FUNC_FIND_KEY, tracker.key_mem[idx], tracker.type_mem[idx], 32'h0, 8'd0);
        end
        send_req(FUNC_SORT, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
        send_req(FUNC_FIND_IDX, 24'h0, 3'($urandom_range(TYPE_LAST)), 32'h0, 8'd128);
        send_req(FUNC_FIND_KEY, 24'($urandom()), 3'($urandom()), 32'h0, 8'd0);
        send_req(FUNC_CLEAR, 24'h0, TYPE_BOOL, 32'h0, 8'd0);
    endtask

    task automatic run_random_sequence();
        int          n, m, i, idx, mode;
        logic [2:0]  w;
        logic [31:0] d;
        logic [7:0]  p;
        if ($urandom_range(99) < 8) begin
            send_req(3'($urandom()), 24'($urandom()), 3'($urandom()), $urandom(),
                     8'($urandom()));
            return;
        end
        mode = $urandom_range(2);
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        send_req(FUNC_CLEAR, 24'($urandom()), 3'($urandom()), $urandom(), 8'($urandom()));
        for (i = 0; i < n; i++) begin
            w = ($urandom_range(19) == 0) ? 3'($urandom_range(TYPE_NONE, TYPE_BAD))
                                          : 3'($urandom_range(TYPE_LAST));
            d = $urandom();
            if (w == TYPE_BOOL && $urandom_range(1))
                d[7:0] = 8'h00;
            send_req(FUNC_APPEND, random_key(mode), w, d, 8'($urandom()));
        end
        if ($urandom_range(3) != 0)
            send_req(FUNC_SORT, 24'($urandom()), 3'($urandom()), $urandom(), 8'($urandom()));
        m = $urandom_range(2, 10);
        for (i = 0; i < m; i++) begin
            if (tracker.fill > 0)
                idx = $urandom_range(tracker.fill - 1);
            else
                idx = 0;
            if ($urandom_range(1)) begin
                if (tracker.fill > 0 && $urandom_range(9) < 7) begin
                    w = ($urandom_range(9) < 7) ? tracker.type_mem[idx] : 3'($urandom());
                    send_req(FUNC_FIND_KEY, tracker.key_mem[idx], w, $urandom(),
                             8'($urandom()));
                end else begin
                    send_req(FUNC_FIND_KEY, random_key($urandom_range(2)), 3'($urandom()),
                             $urandom(), 8'($urandom()));
                end
            end else begin
                p = (tracker.fill > 0 && $urandom_range(9) < 8) ? 8'(idx) : 8'($urandom());
                w = ($urandom_range(9) < 7 && int'(p) < tracker.fill) ?
                    tracker.type_mem[p] : 3'($urandom());
                send_req(FUNC_FIND_IDX, 24'($urandom()), w, $urandom(), p);
            end
        end
    endtask

    initial begin
        int phase, start;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin sender_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            start = beats_sent;
            if (phase == 0)
                run_full_table();
            while (beats_sent - start < PHASE_BEATS + (phase == 0 ? ENTRIES : 0))
                run_random_sequence();
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
